// ===== rtl/rmsd_pkg.sv =====
package rmsd_pkg;

	// Default configuration
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 8;

	// Fixed result field widths
	localparam int COUNT_OUT_W = 16;
	localparam int STAT_W      = 24;

	// Items the front may run ahead of the back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_VAR,
		BK_ROOT,
		BK_HOLD
	} back_state_t;

	// Running sum: signed, wide enough for a full count of extreme samples
	function automatic int sum_w(int s, int c);
		return s + c;
	endfunction

	// Running sum of squares: unsigned
	function automatic int sq_w(int s, int c);
		return 2 * s + c - 1;
	endfunction

	// Snapshot handed from front to back: {full, count, sum, square sum}
	function automatic int entry_w(int s, int c);
		return 1 + c + sum_w(s, c) + sq_w(s, c);
	endfunction

endpackage

// ===== rtl/rmsd_if.sv =====
interface rmsd_in_if #(
	parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmsd_out_if ();
	logic                                   valid;
	logic                                   ready;
	logic [rmsd_pkg::COUNT_OUT_W-1:0]       count;
	logic signed [rmsd_pkg::STAT_W-1:0]     mean;
	logic [rmsd_pkg::STAT_W-1:0]            std_dev;
	logic                                   count_full;

	modport source (output valid, output count, output mean, output std_dev,
		output count_full, input ready);
	modport sink   (input valid, input count, input mean, input std_dev,
		input count_full, output ready);
endinterface

// ===== rtl/rmsd_front.sv =====
module rmsd_front #(
	parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS,
	parameter int COUNT_BITS  = rmsd_pkg::COUNT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	rmsd_in_if.sink    samples,
	output logic [rmsd_pkg::entry_w(SAMPLE_BITS, COUNT_BITS)-1:0] entry,
	output logic       entry_valid,
	input  logic       entry_ready
);

	localparam int S     = SAMPLE_BITS;
	localparam int C     = COUNT_BITS;
	localparam int SUM_W = rmsd_pkg::sum_w(S, C);
	localparam int SQ_W  = rmsd_pkg::sq_w(S, C);

	logic                   valid_s1;
	logic signed [S-1:0]    sample_s1;
	logic [2*S-2:0]         sq_s1;
	logic                   restart_s1;

	logic [C-1:0]           cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]        sqsum_q;

	logic signed [2*S-1:0]  sq_full;
	logic                   advance;
	logic [C-1:0]           cnt_base, cnt_d;
	logic signed [SUM_W-1:0] sum_base, sum_d;
	logic [SQ_W-1:0]        sqsum_base, sqsum_d;
	logic                   full;

	// Square the sample on entry; the result is never negative
	assign sq_full = samples.sample * samples.sample;

	assign advance       = valid_s1 && entry_ready;
	assign samples.ready = !valid_s1 || entry_ready;

	// Clear on restart, then add unless the count is saturated
	always_comb begin
		cnt_base   = restart_s1 ? '0 : cnt_q;
		sum_base   = restart_s1 ? '0 : sum_q;
		sqsum_base = restart_s1 ? '0 : sqsum_q;
		full       = (cnt_base == {C{1'b1}});
		if (full) begin
			cnt_d   = cnt_base;
			sum_d   = sum_base;
			sqsum_d = sqsum_base;
		end else begin
			cnt_d   = cnt_base + C'(1);
			sum_d   = sum_base + SUM_W'(sample_s1);
			sqsum_d = sqsum_base + SQ_W'(sq_s1);
		end
	end

	assign entry       = {full, cnt_d, sum_d, sqsum_d};
	assign entry_valid = valid_s1;

	// Hold the accepted item until the queue takes its snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
			sqsum_q  <= '0;
		end else begin
			if (samples.valid && samples.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				cnt_q   <= cnt_d;
				sum_q   <= sum_d;
				sqsum_q <= sqsum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1  <= samples.sample;
			sq_s1      <= sq_full[2*S-2:0];
			restart_s1 <= samples.restart;
		end
	end

endmodule

// ===== rtl/rmsd_queue.sv =====
module rmsd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rmsd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] push_data,
	input  logic             push_valid,
	output logic             push_ready,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid,
	input  logic             pop_ready
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic             push, pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/rmsd_back.sv =====
module rmsd_back #(
	parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS,
	parameter int COUNT_BITS  = rmsd_pkg::COUNT_BITS,
	parameter int FRAC_BITS   = rmsd_pkg::FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [rmsd_pkg::entry_w(SAMPLE_BITS, COUNT_BITS)-1:0] entry,
	input  logic       entry_valid,
	output logic       entry_ready,
	rmsd_out_if.source results
);

	localparam int S      = SAMPLE_BITS;
	localparam int C      = COUNT_BITS;
	localparam int F      = FRAC_BITS;
	localparam int SUM_W  = rmsd_pkg::sum_w(S, C);
	localparam int SQ_W   = rmsd_pkg::sq_w(S, C);
	localparam int MW     = S + F;
	// Mean dividend; the square of the mean follows in the steps left over
	localparam int NA     = SUM_W - 1 + F;
	// Mean-of-squares dividend; NB equals NA + MW
	localparam int NB     = SQ_W + 2 * F;
	localparam int STEP_W = $clog2(NB);
	localparam int CX_W   = (C > rmsd_pkg::COUNT_OUT_W) ? C : rmsd_pkg::COUNT_OUT_W;
	localparam int MX_W   = (MW + 1 > rmsd_pkg::STAT_W) ? MW + 1 : rmsd_pkg::STAT_W;
	localparam int RX_W   = (MW > rmsd_pkg::STAT_W) ? MW : rmsd_pkg::STAT_W;

	rmsd_pkg::back_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	logic [C-1:0]      div_q;
	logic              full_q, neg_q;
	logic [C-1:0]      rem_a_q, rem_b_q;
	logic [NA-1:0]     dq_a_q;
	logic [NB-1:0]     dq_b_q;
	logic [MW-1:0]     mean_q;
	logic [2*MW-1:0]   prod_q, rad_q;
	logic [MW-1:0]     root_q;
	logic [MW:0]       srem_q;

	logic              out_valid_q;
	logic [rmsd_pkg::COUNT_OUT_W-1:0] out_count_q;
	logic [rmsd_pkg::STAT_W-1:0]      out_mean_q, out_std_q;
	logic              out_full_q;

	logic              out_load;

	// Snapshot fields
	logic [SQ_W-1:0]         in_sqsum;
	logic signed [SUM_W-1:0] in_sum;
	logic [C-1:0]            in_count;
	logic                    in_full;
	logic [SUM_W-1:0]        in_sum_mag;

	assign in_sqsum   = entry[SQ_W-1:0];
	assign in_sum     = entry[SQ_W +: SUM_W];
	assign in_count   = entry[SQ_W + SUM_W +: C];
	assign in_full    = entry[SQ_W + SUM_W + C];
	assign in_sum_mag = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);

	// One restoring division step for each quotient
	logic [C:0]    ra_w, rb_w;
	logic          ra_ge, rb_ge;
	logic [C-1:0]  rem_a_d, rem_b_d;
	logic [NA-1:0] dq_a_d;
	logic [NB-1:0] dq_b_d;
	logic          a_step, a_last, b_last, root_last;

	always_comb begin
		ra_w    = {rem_a_q, dq_a_q[NA-1]};
		ra_ge   = (ra_w >= {1'b0, div_q});
		rem_a_d = ra_ge ? C'(ra_w - {1'b0, div_q}) : ra_w[C-1:0];
		dq_a_d  = {dq_a_q[NA-2:0], ra_ge};
		rb_w    = {rem_b_q, dq_b_q[NB-1]};
		rb_ge   = (rb_w >= {1'b0, div_q});
		rem_b_d = rb_ge ? C'(rb_w - {1'b0, div_q}) : rb_w[C-1:0];
		dq_b_d  = {dq_b_q[NB-2:0], rb_ge};
	end

	assign a_step    = (step_q < STEP_W'(NA));
	assign a_last    = (step_q == STEP_W'(NA - 1));
	assign b_last    = (step_q == STEP_W'(NB - 1));
	assign root_last = (step_q == STEP_W'(MW - 1));

	// Square of the mean, multiplier bits taken MSB first
	logic [2*MW-1:0] prod_d;
	assign prod_d = {prod_q[2*MW-2:0], 1'b0} + (dq_a_q[MW-1] ? (2*MW)'(mean_q) : '0);

	// Variance, clamped at zero
	logic [2*MW-1:0] msq, var_d;
	assign msq   = (2*MW)'(dq_b_q[2*MW-2:0]);
	assign var_d = (msq > prod_q) ? msq - prod_q : '0;

	// One root bit per step
	logic [MW+2:0] sr_w, sr_trial;
	logic          sr_ge;
	logic [MW:0]   srem_d;

	always_comb begin
		sr_w     = {srem_q, rad_q[2*MW-1 -: 2]};
		sr_trial = (MW+3)'({root_q, 2'b01});
		sr_ge    = (sr_w >= sr_trial);
		srem_d   = sr_ge ? (MW+1)'(sr_w - sr_trial) : sr_w[MW:0];
	end

	// Result formatting
	logic signed [MW:0]     mean_s;
	logic signed [MX_W-1:0] mean_x;
	logic [RX_W-1:0]        root_x;
	logic [CX_W-1:0]        count_x;

	assign mean_s  = neg_q ? -$signed({1'b0, mean_q}) : $signed({1'b0, mean_q});
	assign mean_x  = MX_W'(mean_s);
	assign root_x  = RX_W'(root_q);
	assign count_x = CX_W'(div_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmsd_pkg::BK_IDLE: if (entry_valid) state_d = rmsd_pkg::BK_DIV;
			rmsd_pkg::BK_DIV:  if (b_last) state_d = rmsd_pkg::BK_VAR;
			rmsd_pkg::BK_VAR:  state_d = rmsd_pkg::BK_ROOT;
			rmsd_pkg::BK_ROOT: if (root_last) state_d = rmsd_pkg::BK_HOLD;
			rmsd_pkg::BK_HOLD: if (out_load) state_d = rmsd_pkg::BK_IDLE;
			default:           state_d = rmsd_pkg::BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		entry_ready = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			rmsd_pkg::BK_IDLE: entry_ready = 1'b1;
			rmsd_pkg::BK_HOLD: out_load = !out_valid_q || results.ready;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmsd_pkg::BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rmsd_pkg::BK_DIV || state_q == rmsd_pkg::BK_ROOT) begin
				step_q <= (state_d == state_q) ? step_q + STEP_W'(1) : '0;
			end else begin
				step_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rmsd_pkg::BK_IDLE: begin
				if (entry_valid) begin
					div_q   <= in_count;
					full_q  <= in_full;
					neg_q   <= in_sum[SUM_W-1];
					rem_a_q <= '0;
					rem_b_q <= '0;
					dq_a_q  <= NA'(in_sum_mag[SUM_W-2:0]) << F;
					dq_b_q  <= NB'(in_sqsum) << (2 * F);
					prod_q  <= '0;
				end
			end
			rmsd_pkg::BK_DIV: begin
				if (a_step) begin
					rem_a_q <= rem_a_d;
					dq_a_q  <= dq_a_d;
					if (a_last) begin
						mean_q <= dq_a_d[MW-1:0];
					end
				end else begin
					dq_a_q <= dq_a_q << 1;
					prod_q <= prod_d;
				end
				rem_b_q <= rem_b_d;
				dq_b_q  <= dq_b_d;
			end
			rmsd_pkg::BK_VAR: begin
				rad_q  <= var_d;
				root_q <= '0;
				srem_q <= '0;
			end
			rmsd_pkg::BK_ROOT: begin
				rad_q  <= rad_q << 2;
				srem_q <= srem_d;
				root_q <= {root_q[MW-2:0], sr_ge};
			end
			rmsd_pkg::BK_HOLD: begin
				if (out_load) begin
					out_count_q <= count_x[rmsd_pkg::COUNT_OUT_W-1:0];
					out_mean_q  <= mean_x[rmsd_pkg::STAT_W-1:0];
					out_std_q   <= root_x[rmsd_pkg::STAT_W-1:0];
					out_full_q  <= full_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid      = out_valid_q;
	assign results.count      = out_count_q;
	assign results.mean       = out_mean_q;
	assign results.std_dev    = out_std_q;
	assign results.count_full = out_full_q;

endmodule

// ===== rtl/running_mean_std_dev_top.sv =====
// Channel   Dir  Fields                                  Accept
// samples   in   sample[SAMPLE_BITS], restart            valid && ready
// results   out  count[16], mean[24], std_dev[24],       valid && ready
//                count_full
//
// The front takes one item per cycle into a two-item queue while there is
// room, and updates count, sum and sum of squares there. The back takes one
// item at a time, and the next only once the last result is loaded. It runs
// one bit-serial pass of both divisions by the count, with the mean squared
// in the tail of it, then one root bit per cycle.
// Reset clears the accumulators and all handshake state at once.
// A stalled result holds in the output register; the back then waits,
// and the queue lets the front keep taking items until it fills.
module running_mean_std_dev_top #(
	parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS,
	parameter int COUNT_BITS  = rmsd_pkg::COUNT_BITS,
	parameter int FRAC_BITS   = rmsd_pkg::FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	rmsd_in_if.sink    samples,
	rmsd_out_if.source results
);

	localparam int ENTRY_W = rmsd_pkg::entry_w(SAMPLE_BITS, COUNT_BITS);

	logic [ENTRY_W-1:0] push_data, pop_data;
	logic               push_valid, push_ready, pop_valid, pop_ready;

	rmsd_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.entry      (push_data),
		.entry_valid(push_valid),
		.entry_ready(push_ready)
	);

	rmsd_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(rmsd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready)
	);

	rmsd_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (pop_data),
		.entry_valid(pop_valid),
		.entry_ready(pop_ready),
		.results    (results)
	);

endmodule
